@@ src/wsf_pkg.sv @@
package wsf_pkg;

    localparam int PIX_W     = 16;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_LINE  = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // 2 * (sum of neighbours) + 84 * centre = 2 * (sum of all nine) + 82 * centre
    localparam int COL_SUM_W = PIX_W + 2;
    localparam int ACC_W     = PIX_W + 7;
    localparam int ABS_W     = ACC_W - 1;

    // divide by 100: floor(a * ceil(2^29 / 100) / 2^29) is exact for a < 2^22
    localparam int                 RECIP_SHIFT = 29;
    localparam int                 RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP       = 23'd5368710;
    localparam int                 PROD_W      = ABS_W + RECIP_W;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = RQ_PTR_W + 1;

    typedef logic signed [PIX_W-1:0] pixel_t;
    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic [CFG_W-1:0]        cfg_t;

    typedef struct packed {
        logic   drain;
        logic   r_ge1;
        logic   r_ge2;
        logic   last;
        coord_t col;
        coord_t row_m1;
        pixel_t p;
    } op_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   emit_left;
        logic   emit_edge;
        logic   frame_end;
    } meta_t;

    typedef struct packed {
        pixel_t smoothed;
        coord_t row;
        coord_t col;
        logic   frame_end;
    } result_t;

endpackage

@@ src/weighted_3x3_smoothing_filter_core.sv @@
// 3x3 smoothing filter, replicate border: (2 * neighbours + 84 * centre) / 100
// input queue: word = {func, pixel}, taken when push is high and full is low;
//   pixels arrive in row order, then one drain word per column flushes the last row
// result queue: word = {smoothed, out_row, out_col, frame_end}, valid while empty
//   is low, taken when pop is high; result of (y,x) follows pixel (y+1, x+1),
//   the last column of a row gives two words
// config: cfg_valid/cfg_ready (always ready), cfg_index 0 line_length,
//   1 line_count; a write restarts the frame, write only while idle
// throughput: one input word per cycle while full is low; the back end retires
//   one column per cycle while it has result room; one result word out per cycle
// an accepted word passes the op queue, line store read, window, sum, abs and
//   reciprocal multiply registers before its results reach the result queue
// a stalled result side halts the back end once the 8-word result queue has over
//   6 words, then fills the 4-entry op queue, then full rises; nothing is dropped
// reset: queues empty, window zero, counters at (0,0), both registers 1024;
//   line stores need no clearing since no entry feeds a result before it is written
module weighted_3x3_smoothing_filter_core
    import wsf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 func,
    input  pixel_t               pixel,
    output logic                 empty,
    input  logic                 pop,
    output pixel_t               smoothed,
    output coord_t               out_row,
    output coord_t               out_col,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_t                 cfg_data
);

    logic       op_push;
    op_t        op_in;
    logic       op_full;
    logic       op_pop;
    logic       op_empty;
    op_t        op_head;
    logic       res_room;
    logic [1:0] res_n;
    result_t    res_a;
    result_t    res_b;
    result_t    head;

    wsf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_push   (op_push),
        .op        (op_in),
        .op_full   (op_full)
    );

    wsf_op_queue u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wr_op (op_in),
        .full  (op_full),
        .pop   (op_pop),
        .empty (op_empty),
        .rd_op (op_head)
    );

    wsf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_head),
        .op_pop   (op_pop),
        .res_room (res_room),
        .res_n    (res_n),
        .res_a    (res_a),
        .res_b    (res_b)
    );

    wsf_result_queue u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .res_n (res_n),
        .res_a (res_a),
        .res_b (res_b),
        .room  (res_room),
        .pop   (pop),
        .empty (empty),
        .head  (head)
    );

    assign smoothed  = head.smoothed;
    assign out_row   = head.row;
    assign out_col   = head.col;
    assign frame_end = head.frame_end;

endmodule

@@ src/wsf_front.sv @@
module wsf_front
    import wsf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 func,
    input  pixel_t               pixel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_t                 cfg_data,
    output logic                 op_push,
    output op_t                  op,
    input  logic                 op_full
);

    localparam int WIDTH_LIMIT = (MAX_WIDTH < MAX_LINE) ? MAX_WIDTH : MAX_LINE;

    cfg_t   line_length_reg;
    cfg_t   line_count_reg;
    coord_t row_reg;
    coord_t col_reg;
    coord_t drain_reg;
    logic   draining_reg;

    cfg_t   eff_w;
    cfg_t   eff_h;
    coord_t w_last;
    coord_t h_last;
    logic   accept;
    logic   is_drain;
    logic   col_last;
    logic   row_last;
    logic   drain_last;
    logic   cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign full      = op_full;
    assign accept    = push && !op_full;
    assign is_drain  = (func == FUNC_DRAIN);

    always_comb
    begin
        if (line_length_reg < CFG_W'(2))
            eff_w = CFG_W'(2);
        else if (line_length_reg > CFG_W'(WIDTH_LIMIT))
            eff_w = CFG_W'(WIDTH_LIMIT);
        else
            eff_w = line_length_reg;

        if (line_count_reg < CFG_W'(2))
            eff_h = CFG_W'(2);
        else if (line_count_reg > CFG_W'(MAX_LINE))
            eff_h = CFG_W'(MAX_LINE);
        else
            eff_h = line_count_reg;

        w_last     = COORD_W'(eff_w - CFG_W'(1));
        h_last     = COORD_W'(eff_h - CFG_W'(1));
        col_last   = (col_reg == w_last);
        row_last   = (row_reg == h_last);
        drain_last = (drain_reg == w_last);

        op.drain  = is_drain;
        op.col    = is_drain ? drain_reg : col_reg;
        op.row_m1 = is_drain ? h_last : row_reg - COORD_W'(1);
        op.r_ge1  = is_drain || (row_reg != '0);
        op.r_ge2  = is_drain || (row_reg > COORD_W'(1));
        op.last   = is_drain ? drain_last : col_last;
        op.p      = pixel;
        op_push   = accept && (is_drain ? draining_reg : !draining_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= CFG_W'(MAX_LINE);
            line_count_reg  <= CFG_W'(MAX_LINE);
            row_reg         <= '0;
            col_reg         <= '0;
            drain_reg       <= '0;
            draining_reg    <= 1'b0;
        end
        else if (cfg_wr && (cfg_index == REG_LINE_LENGTH || cfg_index == REG_LINE_COUNT))
        begin
            if (cfg_index == REG_LINE_LENGTH)
                line_length_reg <= cfg_data;
            else
                line_count_reg <= cfg_data;
            row_reg      <= '0;
            col_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else if (op_push && !is_drain)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                if (row_last)
                begin
                    draining_reg <= 1'b1;
                    drain_reg    <= '0;
                end
                else
                begin
                    row_reg <= row_reg + COORD_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
        else if (op_push)
        begin
            if (drain_last)
            begin
                draining_reg <= 1'b0;
                drain_reg    <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
            end
            else
            begin
                drain_reg <= drain_reg + COORD_W'(1);
            end
        end
    end

endmodule

@@ src/wsf_op_queue.sv @@
module wsf_op_queue
    import wsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  wr_op,
    output logic full,
    input  logic pop,
    output logic empty,
    output op_t  rd_op
);

    op_t                 slot_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] count_reg;

    assign full  = (count_reg == OQ_CNT_W'(OQ_DEPTH));
    assign empty = (count_reg == '0);
    assign rd_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            count_reg <= count_reg + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
        end
    end

endmodule

@@ src/wsf_back.sv @@
module wsf_back
    import wsf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_empty,
    input  op_t        op,
    output logic       op_pop,
    input  logic       res_room,
    output logic [1:0] res_n,
    output result_t    res_a,
    output result_t    res_b
);

    localparam int STORE_DEPTH = (MAX_WIDTH < MAX_LINE) ? MAX_WIDTH : MAX_LINE;
    localparam int AW          = $clog2(STORE_DEPTH);

    function automatic logic signed [ACC_W-1:0] times82(input logic signed [ACC_W-1:0] x);
        return (x <<< 6) + (x <<< 4) + (x <<< 1);
    endfunction

    pixel_t up_mem  [STORE_DEPTH];
    pixel_t mid_mem [STORE_DEPTH];

    logic   adv;
    logic   take;
    logic   st_wr;
    pixel_t col_u;
    pixel_t col_m;
    pixel_t col_p;

    logic   s1_valid_reg;
    op_t    s1_op_reg;
    pixel_t up_rd_reg;
    pixel_t mid_rd_reg;

    pixel_t win_reg [3][3];

    logic  s2_valid_reg;
    meta_t s2_meta_reg;
    logic signed [COL_SUM_W-1:0] cs [3];
    logic signed [ACC_W-1:0]     tot;
    logic signed [ACC_W-1:0]     acc_left;
    logic signed [ACC_W-1:0]     acc_edge;

    logic                    s3_valid_reg;
    meta_t                   s3_meta_reg;
    logic signed [ACC_W-1:0] acc_left_reg;
    logic signed [ACC_W-1:0] acc_edge_reg;

    logic             s4_valid_reg;
    meta_t            s4_meta_reg;
    logic             neg_left_reg;
    logic             neg_edge_reg;
    logic [ABS_W-1:0] abs_left_reg;
    logic [ABS_W-1:0] abs_edge_reg;

    logic              s5_valid_reg;
    meta_t             s5_meta_reg;
    logic              s5_neg_left_reg;
    logic              s5_neg_edge_reg;
    logic [PIX_W-1:0]  q_left_reg;
    logic [PIX_W-1:0]  q_edge_reg;
    logic [PROD_W-1:0] prod_left;
    logic [PROD_W-1:0] prod_edge;

    assign adv    = res_room;
    assign take   = adv && !op_empty;
    assign op_pop = take;

    // line stores, read ahead one stage, written back with the shifted column
    assign st_wr = adv && s1_valid_reg && !s1_op_reg.drain;

    always_ff @(posedge clk)
    begin
        if (st_wr)
            up_mem[s1_op_reg.col[AW-1:0]] <= mid_rd_reg;
        if (take)
            up_rd_reg <= up_mem[op.col[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (st_wr)
            mid_mem[s1_op_reg.col[AW-1:0]] <= s1_op_reg.p;
        if (take)
            mid_rd_reg <= mid_mem[op.col[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_op_reg <= op;
    end

    // replicate top row for the second row, bottom row while draining
    assign col_m = mid_rd_reg;
    assign col_u = s1_op_reg.r_ge2 ? up_rd_reg : mid_rd_reg;
    assign col_p = s1_op_reg.drain ? mid_rd_reg : s1_op_reg.p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                    win_reg[k][j] <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            if (s1_op_reg.col == '0)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[0][j] <= col_u;
                    win_reg[1][j] <= col_m;
                    win_reg[2][j] <= col_p;
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= col_u;
                win_reg[1][2] <= col_m;
                win_reg[2][2] <= col_p;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg.row       <= s1_op_reg.row_m1;
            s2_meta_reg.col       <= s1_op_reg.col;
            s2_meta_reg.emit_left <= s1_op_reg.r_ge1 && (s1_op_reg.col != '0);
            s2_meta_reg.emit_edge <= s1_op_reg.r_ge1 && s1_op_reg.last;
            s2_meta_reg.frame_end <= s1_op_reg.drain && s1_op_reg.last;
        end
    end

    // weighted sums; right edge sees its last column twice
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            cs[j] = COL_SUM_W'(win_reg[0][j]) + COL_SUM_W'(win_reg[1][j])
                  + COL_SUM_W'(win_reg[2][j]);
        tot      = ACC_W'(cs[0]) + ACC_W'(cs[1]) + ACC_W'(cs[2]);
        acc_left = (tot <<< 1) + times82(ACC_W'(win_reg[1][1]));
        acc_edge = ((ACC_W'(cs[1]) + (ACC_W'(cs[2]) <<< 1)) <<< 1)
                 + times82(ACC_W'(win_reg[1][2]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_meta_reg  <= s2_meta_reg;
            acc_left_reg <= acc_left;
            acc_edge_reg <= acc_edge;
            s4_meta_reg  <= s3_meta_reg;
            neg_left_reg <= acc_left_reg[ACC_W-1];
            neg_edge_reg <= acc_edge_reg[ACC_W-1];
            abs_left_reg <= ABS_W'(acc_left_reg[ACC_W-1] ? -acc_left_reg : acc_left_reg);
            abs_edge_reg <= ABS_W'(acc_edge_reg[ACC_W-1] ? -acc_edge_reg : acc_edge_reg);
            s5_meta_reg     <= s4_meta_reg;
            s5_neg_left_reg <= neg_left_reg;
            s5_neg_edge_reg <= neg_edge_reg;
            q_left_reg      <= prod_left[RECIP_SHIFT +: PIX_W];
            q_edge_reg      <= prod_edge[RECIP_SHIFT +: PIX_W];
        end
    end

    assign prod_left = PROD_W'(abs_left_reg) * PROD_W'(RECIP);
    assign prod_edge = PROD_W'(abs_edge_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_comb
    begin
        res_n = '0;
        if (adv && s5_valid_reg)
            res_n = 2'(s5_meta_reg.emit_left) + 2'(s5_meta_reg.emit_edge);

        res_a.smoothed  = s5_neg_left_reg ? pixel_t'(~q_left_reg + PIX_W'(1))
                                          : pixel_t'(q_left_reg);
        res_a.row       = s5_meta_reg.row;
        res_a.col       = s5_meta_reg.col - COORD_W'(1);
        res_a.frame_end = 1'b0;

        res_b.smoothed  = s5_neg_edge_reg ? pixel_t'(~q_edge_reg + PIX_W'(1))
                                          : pixel_t'(q_edge_reg);
        res_b.row       = s5_meta_reg.row;
        res_b.col       = s5_meta_reg.col;
        res_b.frame_end = s5_meta_reg.frame_end;
    end

endmodule

@@ src/wsf_result_queue.sv @@
module wsf_result_queue
    import wsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] res_n,
    input  result_t    res_a,
    input  result_t    res_b,
    output logic       room,
    input  logic       pop,
    output logic       empty,
    output result_t    head
);

    result_t             slot_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic                deq;

    assign empty = (count_reg == '0);
    assign room  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign head  = slot_reg[rd_ptr_reg];
    assign deq   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (res_n != '0)
            slot_reg[wr_ptr_reg] <= res_a;
        if (res_n == 2'd2)
            slot_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(res_n);
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(1);
            count_reg <= count_reg + RQ_CNT_W'(res_n) - RQ_CNT_W'(deq);
        end
    end

endmodule

@@ src/wsf_checker.sv @@
module wsf_checker
    import wsf_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   empty,
    input logic   pop,
    input pixel_t smoothed,
    input coord_t out_row,
    input coord_t out_col,
    input logic   frame_end
);

    // nothing waits on the result side once reset has been seen at a clock edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // the last pixel of a frame is never in row 0 or column 0
    a_frame_end_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (out_row != '0 && out_col != '0))
        else $error("frame end on first row or column");

    a_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result word vanished");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(smoothed) && $stable(out_row)
                             && $stable(out_col) && $stable(frame_end)))
        else $error("waiting result word changed");

endmodule

bind weighted_3x3_smoothing_filter_core wsf_checker u_wsf_checker (.*);
